>>> rtl/core/iir_band_energy_detector_top_defines.svh
// Assertion macros for the band energy detector.
// No dependencies; included by the files that carry assertions.
`ifndef IIR_BAND_ENERGY_DETECTOR_TOP_DEFINES_SVH
`define IIR_BAND_ENERGY_DETECTOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IBE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBE_ASSERT(lbl, clk, rst, prop, msg)
`define IBE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/ibe_pkg.sv
// Shared types, constants and microcode for the band energy detector.
// No dependencies.
package ibe_pkg;

   localparam int FILTER_HALF_ORDER_DEF = 2;

   localparam int SAMPLE_W   = 12;
   localparam int ENERGY_W   = 40;
   localparam int COEF_W     = 16;
   localparam int Y_W        = 24;
   localparam int PROD_W     = COEF_W + Y_W;
   localparam int ACC_W      = PROD_W + 4;
   localparam int FRAC_W     = 14;
   localparam int WIN_W      = 16;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int TAP_W      = 3;
   localparam int PC_W       = 4;
   localparam int UCODE_LEN  = 12;

   localparam logic [SAMPLE_W-1:0] MIDSCALE = SAMPLE_W'(2048);
   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(256);

   localparam logic [CSR_IDX_W-1:0] CSR_FF_TAPS_0_3 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FF_TAP_4    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_FB_TAPS_1_4 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN  = CSR_IDX_W'(3);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MAC_FF,
      OP_MAC_FB,
      OP_ROUND,
      OP_UPDATE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [TAP_W-1:0]  tap;
      logic              jump_en;
      logic [PC_W-1:0]   jump_to;
      logic              last;
   } ucode_type;

   typedef struct packed {
      logic              mul_en;
      logic              mul_fb;
      logic              acc_first;
      logic [TAP_W-1:0]  tap;
      logic              round_en;
      logic              update_en;
   } ctrl_type;

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   // jump_en steps skip the upper taps at half order one
   localparam ucode_type UCODE [UCODE_LEN] = '{
      '{OP_MAC_FF, 3'd0, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FF, 3'd1, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FF, 3'd2, 1'b1, 4'd5, 1'b0},
      '{OP_MAC_FF, 3'd3, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FF, 3'd4, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FB, 3'd1, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FB, 3'd2, 1'b1, 4'd9, 1'b0},
      '{OP_MAC_FB, 3'd3, 1'b0, 4'd0, 1'b0},
      '{OP_MAC_FB, 3'd4, 1'b0, 4'd0, 1'b0},
      '{OP_NOP,    3'd0, 1'b0, 4'd0, 1'b0},
      '{OP_ROUND,  3'd0, 1'b0, 4'd0, 1'b0},
      '{OP_UPDATE, 3'd0, 1'b0, 4'd0, 1'b1}
   };

endpackage

>>> rtl/core/ibe_if.sv
// Stream interfaces for sample words in and band energy words out.
// Depends on ibe_pkg.
interface ibe_req_if;
   logic                          valid;
   logic                          ready;
   logic [ibe_pkg::SAMPLE_W-1:0]  sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface ibe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ibe_pkg::ENERGY_W-1:0]  band_energy;
   modport source (output valid, output band_energy, input ready);
   modport sink (input valid, input band_energy, output ready);
endinterface

>>> rtl/core/ibe_seq.sv
// Microcode sequencer: step counter, control ROM walk, conditional jumps.
// Depends on ibe_pkg and the assertion macro header.
`include "iir_band_energy_detector_top_defines.svh"

module ibe_seq #(
   parameter int FILTER_HALF_ORDER = ibe_pkg::FILTER_HALF_ORDER_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              stall,
   output logic              idle,
   output ibe_pkg::ctrl_type ctrl
);

   localparam logic ORDER_ONE = (FILTER_HALF_ORDER == 1);

   ibe_pkg::state_type           state_ff, state_in;
   logic [ibe_pkg::PC_W-1:0]     pc_ff, pc_in;
   ibe_pkg::ucode_type           uc;

   assign uc = ibe_pkg::UCODE[pc_ff];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ibe_pkg::S_IDLE: begin
            if (start) state_in = ibe_pkg::S_RUN;
         end
         ibe_pkg::S_RUN: begin
            if (uc.last && !stall) state_in = ibe_pkg::S_IDLE;
         end
         default: state_in = ibe_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (state_ff == ibe_pkg::S_IDLE) begin
         pc_in = '0;
      end else if (!stall) begin
         if (uc.jump_en && ORDER_ONE) pc_in = uc.jump_to;
         else pc_in = pc_ff + ibe_pkg::PC_W'(1);
      end
   end

   always_comb begin
      idle = (state_ff == ibe_pkg::S_IDLE);
      ctrl = '0;
      ctrl.tap = uc.tap;
      if (state_ff == ibe_pkg::S_RUN) begin
         unique case (uc.op)
            ibe_pkg::OP_MAC_FF: begin
               ctrl.mul_en    = 1'b1;
               ctrl.acc_first = (uc.tap == '0);
            end
            ibe_pkg::OP_MAC_FB: begin
               ctrl.mul_en = 1'b1;
               ctrl.mul_fb = 1'b1;
            end
            ibe_pkg::OP_ROUND:  ctrl.round_en  = 1'b1;
            ibe_pkg::OP_UPDATE: ctrl.update_en = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ibe_pkg::S_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   `IBE_ASSERT(a_end_to_idle, clock, reset, (state_ff == ibe_pkg::S_RUN && uc.last && !stall) |=> (state_ff == ibe_pkg::S_IDLE), "program end did not return to idle")
   `IBE_ASSERT(a_pc_range, clock, reset, (state_ff == ibe_pkg::S_RUN) |-> (pc_ff < ibe_pkg::PC_W'(ibe_pkg::UCODE_LEN)), "step counter past program")
   `IBE_ASSERT_ALWAYS(a_stall_at_update, clock, stall |-> ctrl.update_en, "stall outside update step")

endmodule

>>> rtl/core/ibe_dp.sv
// Datapath: shared MAC, round and saturate, histories, window sum, result word.
// Depends on ibe_pkg and the assertion macro header.
`include "iir_band_energy_detector_top_defines.svh"

module ibe_dp #(
   parameter int FILTER_HALF_ORDER = ibe_pkg::FILTER_HALF_ORDER_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ibe_pkg::ctrl_type               ctrl,
   input  logic                            start,
   input  logic [ibe_pkg::SAMPLE_W-1:0]    sample_in,
   input  logic [ibe_pkg::CSR_DATA_W-1:0]  ff_taps,
   input  logic [ibe_pkg::COEF_W-1:0]      ff_tap4,
   input  logic [ibe_pkg::CSR_DATA_W-1:0]  fb_taps,
   input  logic [ibe_pkg::WIN_W-1:0]       window_len,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [ibe_pkg::ENERGY_W-1:0]    rsp_energy,
   output logic                            stall
);

   localparam int HIST_LEN   = 2 * FILTER_HALF_ORDER;
   localparam int HIST_IDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int SAMPLE_W   = ibe_pkg::SAMPLE_W;
   localparam int Y_W        = ibe_pkg::Y_W;
   localparam int ACC_W      = ibe_pkg::ACC_W;
   localparam int PROD_W     = ibe_pkg::PROD_W;
   localparam int COEF_W     = ibe_pkg::COEF_W;
   localparam int ENERGY_W   = ibe_pkg::ENERGY_W;
   localparam int WIN_W      = ibe_pkg::WIN_W;
   localparam int TAP_W      = ibe_pkg::TAP_W;
   localparam int FRAC_W     = ibe_pkg::FRAC_W;
   localparam int TOP_W      = ACC_W - Y_W + 1;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] ih_ff [HIST_LEN];
   logic signed [Y_W-1:0]      oh_ff [HIST_LEN];
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       pvld_ff, psub_ff, pfirst_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [Y_W-1:0]      y_ff, y_in;
   logic [ENERGY_W-1:0]        sum_ff;
   logic [WIN_W-1:0]           count_ff;
   logic                       rsp_valid_ff;
   logic [ENERGY_W-1:0]        rsp_energy_ff;

   logic [TAP_W-1:0]           tap_m1;
   logic [HIST_IDX_W-1:0]      hidx;
   logic signed [COEF_W-1:0]   coef;
   logic signed [Y_W-1:0]      operand;
   logic signed [ACC_W-1:0]    rnd, quo;
   logic [TOP_W-1:0]           quo_top;
   logic [Y_W-1:0]             mag;
   logic [ENERGY_W:0]          sum_wide;
   logic [ENERGY_W-1:0]        sum_sat;
   logic [WIN_W:0]             count_next;
   logic [WIN_W-1:0]           win;
   logic                       emit, update;

   assign tap_m1 = ctrl.tap - TAP_W'(1);
   assign hidx   = tap_m1[HIST_IDX_W-1:0];

   always_comb begin
      coef = '0;
      if (ctrl.mul_fb) begin
         case (tap_m1[1:0])
            2'd0:    coef = fb_taps[15:0];
            2'd1:    coef = fb_taps[31:16];
            2'd2:    coef = fb_taps[47:32];
            default: coef = fb_taps[63:48];
         endcase
      end else begin
         case (ctrl.tap)
            3'd0:    coef = ff_taps[15:0];
            3'd1:    coef = ff_taps[31:16];
            3'd2:    coef = ff_taps[47:32];
            3'd3:    coef = ff_taps[63:48];
            default: coef = ff_tap4;
         endcase
      end
   end

   always_comb begin
      if (ctrl.mul_fb) operand = oh_ff[hidx];
      else if (ctrl.tap == '0) operand = Y_W'(x_ff);
      else operand = Y_W'(ih_ff[hidx]);
   end

   assign prod_in = PROD_W'(coef * operand);

   always_comb begin
      acc_in = acc_ff;
      if (pvld_ff) begin
         if (pfirst_ff) acc_in = psub_ff ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
         else if (psub_ff) acc_in = acc_ff - ACC_W'(prod_ff);
         else acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, then clamp to the 24-bit output range
   assign rnd     = acc_ff + ACC_W'(1 << (FRAC_W - 1));
   assign quo     = rnd >>> FRAC_W;
   assign quo_top = quo[ACC_W-1:Y_W-1];

   always_comb begin
      if (quo_top == '0 || quo_top == '1) y_in = quo[Y_W-1:0];
      else if (quo[ACC_W-1]) y_in = {1'b1, {(Y_W-1){1'b0}}};
      else y_in = {1'b0, {(Y_W-1){1'b1}}};
   end

   assign mag        = y_ff[Y_W-1] ? (~y_ff + Y_W'(1)) : y_ff;
   assign sum_wide   = {1'b0, sum_ff} + (ENERGY_W + 1)'(mag);
   assign sum_sat    = sum_wide[ENERGY_W] ? '1 : sum_wide[ENERGY_W-1:0];
   assign count_next = {1'b0, count_ff} + (WIN_W + 1)'(1);
   assign win        = (window_len == '0) ? WIN_W'(1) : window_len;
   assign emit       = (count_next >= {1'b0, win});
   assign stall      = ctrl.update_en && emit && rsp_valid_ff && !rsp_ready;
   assign update     = ctrl.update_en && !stall;

   always_ff @(posedge clock) begin
      if (start) x_ff <= sample_in - ibe_pkg::MIDSCALE;
      prod_ff   <= prod_in;
      psub_ff   <= ctrl.mul_fb;
      pfirst_ff <= ctrl.acc_first;
      acc_ff    <= acc_in;
      if (ctrl.round_en) y_ff <= y_in;
      if (update && emit) rsp_energy_ff <= sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         for (int i = 0; i < HIST_LEN; i++) begin
            ih_ff[i] <= '0;
            oh_ff[i] <= '0;
         end
      end else begin
         pvld_ff <= ctrl.mul_en;
         if (update && emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (update) begin
            if (emit) begin
               sum_ff   <= '0;
               count_ff <= '0;
               for (int i = 0; i < HIST_LEN; i++) begin
                  ih_ff[i] <= '0;
                  oh_ff[i] <= '0;
               end
            end else begin
               sum_ff   <= sum_sat;
               count_ff <= count_next[WIN_W-1:0];
               for (int i = 1; i < HIST_LEN; i++) begin
                  ih_ff[i] <= ih_ff[i-1];
                  oh_ff[i] <= oh_ff[i-1];
               end
               ih_ff[0] <= x_ff;
               oh_ff[0] <= y_ff;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_energy = rsp_energy_ff;

   `IBE_ASSERT(a_emit_sets_valid, clock, reset, (update && emit) |=> rsp_valid_ff, "window end lost its result word")
   `IBE_ASSERT(a_emit_clears_run, clock, reset, (update && emit) |=> (count_ff == '0 && sum_ff == '0), "window end did not clear the run")
   `IBE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_energy_ff)), "held result word changed")

endmodule

>>> rtl/core/iir_band_energy_detector_top.sv
// Band energy detector top: register file, sequencer and datapath.
// Depends on ibe_pkg, ibe_if, ibe_seq and ibe_dp.
// A new sample word is taken only once the single shared MAC has stepped through the microcode
// program, and after any waits while a full result word is held.
// Reset (synchronous, active high): histories, sum and count cleared, taps zero, window 256.
module iir_band_energy_detector_top #(
   parameter int FILTER_HALF_ORDER = ibe_pkg::FILTER_HALF_ORDER_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ibe_req_if.sink                         req,
   ibe_rsp_if.source                       rsp,
   input  logic                            csr_we,
   input  logic [ibe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ibe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [ibe_pkg::CSR_DATA_W-1:0] ff_taps_ff;
   logic [ibe_pkg::COEF_W-1:0]     ff_tap4_ff;
   logic [ibe_pkg::CSR_DATA_W-1:0] fb_taps_ff;
   logic [ibe_pkg::WIN_W-1:0]      window_ff;
   logic                           idle, start, stall;
   ibe_pkg::ctrl_type              ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_taps_ff <= '0;
         ff_tap4_ff <= '0;
         fb_taps_ff <= '0;
         window_ff  <= ibe_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ibe_pkg::CSR_FF_TAPS_0_3: ff_taps_ff <= csr_wdata;
            ibe_pkg::CSR_FF_TAP_4:    ff_tap4_ff <= csr_wdata[ibe_pkg::COEF_W-1:0];
            ibe_pkg::CSR_FB_TAPS_1_4: fb_taps_ff <= csr_wdata;
            ibe_pkg::CSR_WINDOW_LEN:  window_ff  <= csr_wdata[ibe_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign req.ready = idle;
   assign start     = req.valid && idle;

   ibe_seq #(
      .FILTER_HALF_ORDER (FILTER_HALF_ORDER)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stall (stall),
      .idle  (idle),
      .ctrl  (ctrl)
   );

   ibe_dp #(
      .FILTER_HALF_ORDER (FILTER_HALF_ORDER)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .start      (start),
      .sample_in  (req.sample),
      .ff_taps    (ff_taps_ff),
      .ff_tap4    (ff_tap4_ff),
      .fb_taps    (fb_taps_ff),
      .window_len (window_ff),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp.valid),
      .rsp_energy (rsp.band_energy),
      .stall      (stall)
   );

endmodule
